FILE: rtl/core/bks_pkg.sv
// Package of types, constants and arithmetic helpers for the body kinematics block.
package bks_pkg;

  typedef enum logic [2:0] {
    ACT_SET_POS  = 3'd0,
    ACT_SET_VEL  = 3'd1,
    ACT_SET_ACC  = 3'd2,
    ACT_VEL_STEP = 3'd3,
    ACT_ACC_STEP = 3'd4,
    ACT_BACKWARD = 3'd5
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SQX,
    ST_SQY,
    ST_SQM,
    ST_CMP,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_SCALE,
    ST_DIV_LOAD_LIM,
    ST_DIV,
    ST_LIM_WB,
    ST_STORE,
    ST_DIV_LOAD_BACK,
    ST_BACK_WB,
    ST_FINISH
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DISPATCH,
    OP_SQX,
    OP_SQY,
    OP_SQM,
    OP_CMP,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_SCALE,
    OP_DIV_LOAD_LIM,
    OP_DIV_STEP,
    OP_LIM_WB,
    OP_STORE,
    OP_DIV_LOAD_BACK,
    OP_BACK_WB
  } op_e;

  typedef enum logic {
    REG_MAX_SPEED = 1'b0,
    REG_MAX_ACCEL = 1'b1
  } reg_e;

  localparam int unsigned CNT_W          = 6;
  localparam int unsigned SQRT_STEPS     = 32;
  localparam int unsigned DIV_LIM_STEPS  = 31;
  localparam int unsigned DIV_BACK_STEPS = 49;
  localparam logic [30:0] LIMIT_RESET    = 31'h7FFF_FFFF;

  typedef struct packed {
    op_e  op;
    logic sel_y;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       bad;
    logic       clamp_need;
  } dp_stat_t;

  // Magnitude of a signed word; the most negative value maps to 2^31.
  function automatic logic [31:0] abs32(logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // Clip a 33-bit sum to the signed 32-bit range; the top bit flags a clip.
  function automatic logic [32:0] sat32(logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return {1'b1, (v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF)};
    end
    return {1'b0, v[31:0]};
  endfunction

  // floor(c * dt / 2^16) with dt in unsigned Q0.16.
  function automatic logic signed [31:0] scale_dt(logic signed [31:0] c, logic [15:0] dt);
    logic signed [48:0] p;
    p = $signed({{17{c[31]}}, c}) * $signed({33'b0, dt});
    return p[47:16];
  endfunction

endpackage

FILE: rtl/core/bks_if.sv
// Request and result channel interfaces of the body kinematics block.
interface bks_in_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic              keep_previous;
  logic [15:0]       time_step;

  modport source (output valid, action, vec_x, vec_y, keep_previous, time_step,
                  input ready);
  modport sink   (input valid, action, vec_x, vec_y, keep_previous, time_step,
                  output ready);
endinterface

interface bks_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic               was_clamped;
  logic               saturated;
  logic               bad_step;

  modport source (output valid, pos_x, pos_y, vel_x, vel_y, was_clamped, saturated,
                  bad_step, input ready);
  modport sink   (input valid, pos_x, pos_y, vel_x, vel_y, was_clamped, saturated,
                  bad_step, output ready);
endinterface

FILE: rtl/core/bks_ctrl.sv
// Sequencer that steps the kinematics datapath through each request.
module bks_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  bks_pkg::dp_stat_t stat_i,
  output bks_pkg::dp_cmd_t  cmd_o
);
  import bks_pkg::*;

  state_e           state_q, state_d;
  logic             sel_q, sel_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] div_last;
  logic             is_limit_act;

  assign div_last = (stat_i.action == ACT_BACKWARD) ? CNT_W'(DIV_BACK_STEPS - 1)
                                                    : CNT_W'(DIV_LIM_STEPS - 1);
  assign is_limit_act = (stat_i.action == ACT_SET_VEL) || (stat_i.action == ACT_SET_ACC) ||
                        (stat_i.action == ACT_ACC_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    sel_d          = sel_q;
    cnt_d          = cnt_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    in_ready_o     = 1'b0;
    cmd_o.op       = OP_NONE;
    cmd_o.sel_y    = sel_q;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd_o.op = OP_DISPATCH;
        sel_d    = 1'b0;
        priority if (stat_i.bad) begin
          state_d = ST_FINISH;
        end else if (is_limit_act) begin
          state_d = ST_SQX;
        end else if (stat_i.action == ACT_BACKWARD) begin
          state_d = ST_DIV_LOAD_BACK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SQX: begin
        cmd_o.op = OP_SQX;
        state_d  = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.op = OP_SQY;
        state_d  = ST_SQM;
      end
      ST_SQM: begin
        cmd_o.op = OP_SQM;
        state_d  = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.op = OP_CMP;
        state_d  = stat_i.clamp_need ? ST_SQRT_LOAD : ST_STORE;
      end
      ST_SQRT_LOAD: begin
        cmd_o.op = OP_SQRT_LOAD;
        cnt_d    = '0;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          sel_d   = 1'b0;
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_DIV_LOAD_LIM;
      end
      ST_DIV_LOAD_LIM: begin
        cmd_o.op = OP_DIV_LOAD_LIM;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == div_last) begin
          state_d = (stat_i.action == ACT_BACKWARD) ? ST_BACK_WB : ST_LIM_WB;
        end
      end
      ST_LIM_WB: begin
        cmd_o.op = OP_LIM_WB;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_SCALE;
        end else begin
          state_d = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd_o.op = OP_STORE;
        state_d  = ST_FINISH;
      end
      ST_DIV_LOAD_BACK: begin
        cmd_o.op = OP_DIV_LOAD_BACK;
        cnt_d    = '0;
        state_d  = ST_DIV;
      end
      ST_BACK_WB: begin
        cmd_o.op = OP_BACK_WB;
        if (!sel_q) begin
          sel_d   = 1'b1;
          state_d = ST_DIV_LOAD_BACK;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/core/bks_dp.sv
// Datapath with body state, a shared product register, square root and divider.
module bks_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bks_pkg::dp_cmd_t   cmd_i,
  output bks_pkg::dp_stat_t  stat_o,
  input  logic [30:0]        max_speed_i,
  input  logic [30:0]        max_accel_i,
  input  logic [2:0]         action_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic               keep_previous_i,
  input  logic [15:0]        time_step_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] vel_x_o,
  output logic signed [31:0] vel_y_o,
  output logic               was_clamped_o,
  output logic               saturated_o,
  output logic               bad_step_o
);
  import bks_pkg::*;

  logic [2:0]         act_q;
  logic               keep_q;
  logic [15:0]        dt_q;
  logic signed [31:0] wx_q, wy_q;
  logic signed [31:0] pos_x_q, pos_y_q, prev_x_q, prev_y_q;
  logic signed [31:0] vel_x_q, vel_y_q, acc_x_q, acc_y_q;
  logic [63:0]        prod_q, m2_q, sqn_q;
  logic [33:0]        srem_q;
  logic [31:0]        root_q;
  logic [31:0]        drem_q, dvs_q;
  logic [63:0]        dq_q;
  logic               neg_q;
  logic               clamp_q, sat_q, bad_q;

  logic [31:0]        lim;
  logic signed [31:0] w_sel;
  logic               acc_int;
  logic signed [31:0] src_x, src_y, base_x, base_y;
  logic signed [31:0] sc_x, sc_y;
  logic [32:0]        sum_x, sum_y;
  logic [35:0]        s_trial_r, s_trial;
  logic [32:0]        d_trial;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [48:0]        bq;
  logic [30:0]        lq;
  logic               bad;

  // The working vector holds the supplied vector until the acceleration step or the limiter rewrites it.
  function automatic logic signed [31:0] vec_x_q_sel(logic y);
    return y ? wy_q : wx_q;
  endfunction

  function automatic logic signed [31:0] back_val(logic [48:0] q, logic n);
    if (!n) begin
      return (q[48:31] != '0) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    end
    if ((q[48:32] != '0) || (q[31] && (q[30:0] != '0))) begin
      return 32'sh8000_0000;
    end
    return $signed(32'(-q[31:0]));
  endfunction

  function automatic logic back_sat(logic [48:0] q, logic n);
    if (!n) begin
      return q[48:31] != '0;
    end
    return (q[48:32] != '0) || (q[31] && (q[30:0] != '0));
  endfunction

  assign bad = ((act_q == ACT_VEL_STEP) || (act_q == ACT_ACC_STEP) ||
                (act_q == ACT_BACKWARD)) && (dt_q == '0);
  assign lim = {1'b0, (act_q == ACT_SET_ACC) ? max_accel_i : max_speed_i};
  assign w_sel = cmd_i.sel_y ? wy_q : wx_q;

  // One pair of dt scalers serves both integrations; the sum is saturated.
  assign acc_int = (cmd_i.op == OP_DISPATCH) && (act_q == ACT_ACC_STEP);
  assign src_x  = acc_int ? acc_x_q : ((cmd_i.op == OP_STORE) ? wx_q : vel_x_q);
  assign src_y  = acc_int ? acc_y_q : ((cmd_i.op == OP_STORE) ? wy_q : vel_y_q);
  assign base_x = acc_int ? vel_x_q : pos_x_q;
  assign base_y = acc_int ? vel_y_q : pos_y_q;
  assign sc_x   = scale_dt(src_x, dt_q);
  assign sc_y   = scale_dt(src_y, dt_q);
  assign sum_x = sat32($signed({base_x[31], base_x}) + $signed({sc_x[31], sc_x}));
  assign sum_y = sat32($signed({base_y[31], base_y}) + $signed({sc_y[31], sc_y}));

  assign s_trial_r = {srem_q, sqn_q[63:62]};
  assign s_trial   = {2'b00, root_q, 2'b01};
  assign d_trial   = {drem_q, dq_q[63]};

  assign diff = cmd_i.sel_y ? ($signed({pos_y_q[31], pos_y_q}) - $signed({prev_y_q[31], prev_y_q}))
                            : ($signed({pos_x_q[31], pos_x_q}) - $signed({prev_x_q[31], prev_x_q}));
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign bq = dq_q[48:0];
  assign lq = dq_q[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q  <= '0;
      pos_y_q  <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      vel_x_q  <= '0;
      vel_y_q  <= '0;
      acc_x_q  <= '0;
      acc_y_q  <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_DISPATCH: begin
          if (!bad) begin
            if (act_q == ACT_SET_POS) begin
              if (keep_q) begin
                prev_x_q <= pos_x_q;
                prev_y_q <= pos_y_q;
              end
              pos_x_q <= vec_x_q_sel(1'b0);
              pos_y_q <= vec_x_q_sel(1'b1);
            end else if (act_q == ACT_VEL_STEP) begin
              prev_x_q <= pos_x_q;
              prev_y_q <= pos_y_q;
              pos_x_q  <= sum_x[31:0];
              pos_y_q  <= sum_y[31:0];
            end
          end
        end
        OP_STORE: begin
          if (act_q == ACT_SET_ACC) begin
            acc_x_q <= wx_q;
            acc_y_q <= wy_q;
          end else begin
            vel_x_q <= wx_q;
            vel_y_q <= wy_q;
          end
          if (act_q == ACT_ACC_STEP) begin
            prev_x_q <= pos_x_q;
            prev_y_q <= pos_y_q;
            pos_x_q  <= sum_x[31:0];
            pos_y_q  <= sum_y[31:0];
          end
        end
        OP_BACK_WB: begin
          if (cmd_i.sel_y) begin
            vel_y_q <= back_val(bq, neg_q);
          end else begin
            vel_x_q <= back_val(bq, neg_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        act_q   <= action_i;
        keep_q  <= keep_previous_i;
        dt_q    <= time_step_i;
        wx_q    <= vec_x_i;
        wy_q    <= vec_y_i;
        clamp_q <= 1'b0;
        sat_q   <= 1'b0;
        bad_q   <= 1'b0;
      end
      OP_DISPATCH: begin
        bad_q <= bad;
        if (!bad && (act_q == ACT_ACC_STEP)) begin
          wx_q  <= sum_x[31:0];
          wy_q  <= sum_y[31:0];
          sat_q <= sum_x[32] | sum_y[32];
        end else if (!bad && (act_q == ACT_VEL_STEP)) begin
          sat_q <= sum_x[32] | sum_y[32];
        end
      end
      OP_SQX: prod_q <= abs32(wx_q) * abs32(wx_q);
      OP_SQY: begin
        m2_q   <= prod_q;
        prod_q <= abs32(wy_q) * abs32(wy_q);
      end
      OP_SQM: begin
        m2_q   <= m2_q + prod_q;
        prod_q <= lim * lim;
      end
      OP_CMP: begin
        if (m2_q > prod_q) begin
          clamp_q <= 1'b1;
        end
      end
      OP_SQRT_LOAD: begin
        sqn_q  <= m2_q;
        srem_q <= '0;
        root_q <= '0;
      end
      OP_SQRT_STEP: begin
        sqn_q <= {sqn_q[61:0], 2'b00};
        if (s_trial_r >= s_trial) begin
          srem_q <= 34'(s_trial_r - s_trial);
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          srem_q <= s_trial_r[33:0];
          root_q <= {root_q[30:0], 1'b0};
        end
      end
      OP_SCALE: begin
        prod_q <= abs32(w_sel) * lim;
        neg_q  <= w_sel[31];
      end
      OP_DIV_LOAD_LIM: begin
        drem_q <= prod_q[62:31];
        dq_q   <= {prod_q[30:0], 33'b0};
        dvs_q  <= root_q;
      end
      OP_DIV_LOAD_BACK: begin
        neg_q  <= diff[32];
        drem_q <= '0;
        dq_q   <= {diff_mag, 31'b0};
        dvs_q  <= {16'b0, dt_q};
      end
      OP_DIV_STEP: begin
        if (d_trial >= {1'b0, dvs_q}) begin
          drem_q <= 32'(d_trial - {1'b0, dvs_q});
          dq_q   <= {dq_q[62:0], 1'b1};
        end else begin
          drem_q <= d_trial[31:0];
          dq_q   <= {dq_q[62:0], 1'b0};
        end
      end
      OP_LIM_WB: begin
        if (cmd_i.sel_y) begin
          wy_q <= neg_q ? $signed(32'(-{1'b0, lq})) : $signed({1'b0, lq});
        end else begin
          wx_q <= neg_q ? $signed(32'(-{1'b0, lq})) : $signed({1'b0, lq});
        end
      end
      OP_STORE: begin
        if (act_q == ACT_ACC_STEP) begin
          sat_q <= sat_q | sum_x[32] | sum_y[32];
        end
      end
      OP_BACK_WB: sat_q <= sat_q | back_sat(bq, neg_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      pos_x_o       <= pos_x_q;
      pos_y_o       <= pos_y_q;
      vel_x_o       <= vel_x_q;
      vel_y_o       <= vel_y_q;
      was_clamped_o <= clamp_q;
      saturated_o   <= sat_q;
      bad_step_o    <= bad_q;
    end
  end

  assign stat_o.action     = act_q;
  assign stat_o.bad        = bad;
  assign stat_o.clamp_need = m2_q > prod_q;

endmodule

FILE: rtl/core/body_kinematics_step.sv
// Top level of the body kinematics block: configuration registers, sequencer and datapath.
//
// The block keeps one 2D body's position, previous position, velocity and acceleration in
// signed Q16.16 and runs one request at a time. Setting position, an unknown action code,
// a velocity step and a request with a zero time step go from dispatch straight to the
// finish state, which loads the output register. Setting velocity or acceleration, and the
// acceleration step, add a squared magnitude test; when the magnitude limit fires, a
// bit-serial square root and a bit-serial division per component follow. The backward
// update runs the same divider once per component. A finished result waits in an output
// register, so a new request is taken as soon as the sequencer is back at rest. The limits
// max_speed and max_accel are written over the APB port at byte addresses 0 and 4 and read
// back on prdata; the user must write them only while the block is idle, which the block
// itself does not enforce.
module body_kinematics_step (
  input  logic        clk_i,
  input  logic        rst_ni,
  bks_in_if.sink      in_req,
  bks_out_if.source   out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bks_pkg::*;

  logic [30:0] max_speed_q, max_accel_q;
  logic        cfg_wr;
  dp_cmd_t     cmd;
  dp_stat_t    stat;

  // The port never stalls; a write lands in the access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q <= LIMIT_RESET;
      max_accel_q <= LIMIT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_SPEED) begin
        max_speed_q <= pwdata[30:0];
      end else begin
        max_accel_q <= pwdata[30:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_MAX_SPEED) ? {1'b0, max_speed_q} : {1'b0, max_accel_q};

  // The sequencer owns the handshakes and the result valid flag.
  bks_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req.valid),
    .in_ready_o  (in_req.ready),
    .out_ready_i (out_res.ready),
    .out_valid_o (out_res.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the body state and the result payload.
  bks_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .max_speed_i     (max_speed_q),
    .max_accel_i     (max_accel_q),
    .action_i        (in_req.action),
    .vec_x_i         (in_req.vec_x),
    .vec_y_i         (in_req.vec_y),
    .keep_previous_i (in_req.keep_previous),
    .time_step_i     (in_req.time_step),
    .pos_x_o         (out_res.pos_x),
    .pos_y_o         (out_res.pos_y),
    .vel_x_o         (out_res.vel_x),
    .vel_y_o         (out_res.vel_y),
    .was_clamped_o   (out_res.was_clamped),
    .saturated_o     (out_res.saturated),
    .bad_step_o      (out_res.bad_step)
  );

endmodule

FILE: rtl/core/bks_checker.sv
// Port-level assertions for the body kinematics block and their binding.
module bks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_pos_x_i
);

  // A stalled result keeps its valid and its pos_x payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_pos_x_i))
    else $error("stalled result changed");

  // One request at a time: taking a request closes the input.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // A new result only appears at the end of work on a request.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result without request in work");

endmodule

bind body_kinematics_step bks_checker u_bks_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_req.valid),
  .in_ready_i  (in_req.ready),
  .out_valid_i (out_res.valid),
  .out_ready_i (out_res.ready),
  .out_pos_x_i (out_res.pos_x)
);

FILE: test/body_kinematics_step_test.sv
// Self-checking testbench for the body kinematics block, with a predictor and random requests.
`timescale 1ns / 1ps

module body_kinematics_step_test;
  import bks_pkg::*;

  typedef struct {
    logic [2:0]         action;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               keep;
    logic [15:0]        dt;
  } kin_req_t;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               clamped;
    logic               sat;
    logic               bad;
  } kin_res_t;

  localparam longint S32_HI = 64'sd2147483647;
  localparam longint S32_LO = -64'sd2147483648;
  // Settle time after draining, with a margin over the longest busy stretch of the block.
  localparam int unsigned SETTLE_CYCLES = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  bks_in_if  req_bus ();
  bks_out_if res_bus ();

  body_kinematics_step dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_req  (req_bus),
    .out_res (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Shadow of the body state and of the two magnitude limits.
  longint          body_px, body_py, body_qx, body_qy;
  longint          body_vx, body_vy, body_ax, body_ay;
  longint unsigned lim_speed, lim_accel;
  bit              flag_sat;

  kin_res_t expected_results[$];
  int unsigned error_count;
  int unsigned sent_count;
  int unsigned checked_count;
  // When set, neither side idles: this gives one long back-to-back stretch.
  bit          no_idle;

  function automatic longint clip32(longint v);
    if (v > S32_HI) begin
      flag_sat = 1'b1;
      return S32_HI;
    end
    if (v < S32_LO) begin
      flag_sat = 1'b1;
      return S32_LO;
    end
    return v;
  endfunction

  // floor(c * dt / 2^16): an arithmetic shift rounds toward minus infinity.
  function automatic longint times_dt(longint c, logic [15:0] dt);
    longint p;
    p = c * longint'({48'd0, dt});
    return p >>> 16;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Scale the vector by lim/|v| when its squared magnitude is strictly above lim^2.
  function automatic bit clamp_vec(inout longint x, inout longint y, input longint unsigned lim);
    longint unsigned mx, my, m2, mag;
    mx = (x < 0) ? longint'(-x) : longint'(x);
    my = (y < 0) ? longint'(-y) : longint'(y);
    m2 = mx * mx + my * my;
    if (m2 <= lim * lim) return 1'b0;
    mag = int_sqrt(m2);
    x = (x * longint'(lim)) / longint'(mag);
    y = (y * longint'(lim)) / longint'(mag);
    return 1'b1;
  endfunction

  function automatic void euler_advance(logic [15:0] dt);
    body_qx = body_px;
    body_qy = body_py;
    body_px = clip32(body_px + times_dt(body_vx, dt));
    body_py = clip32(body_py + times_dt(body_vy, dt));
  endfunction

  // Apply one request to the shadow state and return the result it must produce.
  function automatic kin_res_t predict_body(kin_req_t r);
    kin_res_t res;
    longint   nx, ny;
    bit       clamped;
    clamped  = 1'b0;
    flag_sat = 1'b0;
    res.bad  = 1'b0;
    nx = longint'(r.vx);
    ny = longint'(r.vy);
    if ((r.action == ACT_VEL_STEP || r.action == ACT_ACC_STEP || r.action == ACT_BACKWARD)
        && r.dt == 16'd0) begin
      res.bad = 1'b1;
    end else begin
      case (r.action)
        ACT_SET_POS: begin
          if (r.keep) begin
            body_qx = body_px;
            body_qy = body_py;
          end
          body_px = nx;
          body_py = ny;
        end
        ACT_SET_VEL: begin
          clamped = clamp_vec(nx, ny, lim_speed);
          body_vx = nx;
          body_vy = ny;
        end
        ACT_SET_ACC: begin
          clamped = clamp_vec(nx, ny, lim_accel);
          body_ax = nx;
          body_ay = ny;
        end
        ACT_VEL_STEP: euler_advance(r.dt);
        ACT_ACC_STEP: begin
          nx = clip32(body_vx + times_dt(body_ax, r.dt));
          ny = clip32(body_vy + times_dt(body_ay, r.dt));
          clamped = clamp_vec(nx, ny, lim_speed);
          body_vx = nx;
          body_vy = ny;
          euler_advance(r.dt);
        end
        ACT_BACKWARD: begin
          // Signed division truncates toward zero, as the block does.
          body_vx = clip32(((body_px - body_qx) * 65536) / longint'({48'd0, r.dt}));
          body_vy = clip32(((body_py - body_qy) * 65536) / longint'({48'd0, r.dt}));
        end
        default: ;
      endcase
    end
    res.pos_x   = body_px[31:0];
    res.pos_y   = body_py[31:0];
    res.vel_x   = body_vx[31:0];
    res.vel_y   = body_vy[31:0];
    res.clamped = clamped;
    res.sat     = flag_sat;
    return res;
  endfunction

  function automatic bit want_idle();
    return !no_idle && ($urandom_range(0, 99) < 24);
  endfunction

  // Present one request and hold it until the block takes it. valid stays high afterwards,
  // so that back-to-back requests never lower and raise it within one time step.
  task automatic send_request(kin_req_t r);
    if (want_idle()) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_bus.valid         <= 1'b1;
    req_bus.action        <= r.action;
    req_bus.vec_x         <= r.vx;
    req_bus.vec_y         <= r.vy;
    req_bus.keep_previous <= r.keep;
    req_bus.time_step     <= r.dt;
    do @(posedge clk_i); while (!req_bus.ready);
    expected_results.insert(expected_results.size(), predict_body(r));
    sent_count++;
  endtask

  task automatic send_fields(logic [2:0] a, logic [31:0] x, logic [31:0] y, logic k,
                             logic [15:0] dt);
    kin_req_t r;
    r.action = a;
    r.vx     = x;
    r.vy     = y;
    r.keep   = k;
    r.dt     = dt;
    send_request(r);
  endtask

  // Lower valid, wait for every result, then let the block settle before any register write.
  task automatic drain_block();
    req_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // One APB transfer, after which the bus returns to idle.
  task automatic apb_access(logic wr, reg_e idx, logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Write both limits, mirror them in the predictor and read them back.
  task automatic set_limits(logic [30:0] speed, logic [30:0] accel);
    logic [31:0] rd;
    apb_access(1'b1, REG_MAX_SPEED, {1'b0, speed}, rd);
    apb_access(1'b1, REG_MAX_ACCEL, {1'b0, accel}, rd);
    lim_speed = 64'(speed);
    lim_accel = 64'(accel);
    apb_access(1'b0, REG_MAX_SPEED, 32'd0, rd);
    if (rd[30:0] !== speed) begin
      $display("%0t max_speed readback: expected %h actual %h", $time, speed, rd);
      error_count++;
    end
    apb_access(1'b0, REG_MAX_ACCEL, 32'd0, rd);
    if (rd[30:0] !== accel) begin
      $display("%0t max_accel readback: expected %h actual %h", $time, accel, rd);
      error_count++;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'd0;
      3:       return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
      4:       return 32'($signed($urandom) >>> $urandom_range(4, 14));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic kin_req_t pick_request();
    kin_req_t r;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    // Mostly meaningful actions; the two unused codes now and then.
    if (roll < 3) r.action = 3'($urandom_range(6, 7));
    else r.action = 3'($urandom_range(0, 5));
    r.vx   = pick_word();
    r.vy   = pick_word();
    r.keep = 1'($urandom_range(0, 1));
    r.dt   = pick_step();
    return r;
  endfunction

  // Result side: random back-pressure, and every result checked against the oldest prediction.
  always @(posedge clk_i) begin
    kin_res_t exp_r;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual pos %h %h", $time,
                 res_bus.pos_x, res_bus.pos_y);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        checked_count++;
        if (res_bus.pos_x !== exp_r.pos_x) begin
          $display("%0t pos_x: expected %h actual %h", $time, exp_r.pos_x, res_bus.pos_x);
          error_count++;
        end
        if (res_bus.pos_y !== exp_r.pos_y) begin
          $display("%0t pos_y: expected %h actual %h", $time, exp_r.pos_y, res_bus.pos_y);
          error_count++;
        end
        if (res_bus.vel_x !== exp_r.vel_x) begin
          $display("%0t vel_x: expected %h actual %h", $time, exp_r.vel_x, res_bus.vel_x);
          error_count++;
        end
        if (res_bus.vel_y !== exp_r.vel_y) begin
          $display("%0t vel_y: expected %h actual %h", $time, exp_r.vel_y, res_bus.vel_y);
          error_count++;
        end
        if (res_bus.was_clamped !== exp_r.clamped) begin
          $display("%0t was_clamped: expected %b actual %b", $time, exp_r.clamped,
                   res_bus.was_clamped);
          error_count++;
        end
        if (res_bus.saturated !== exp_r.sat) begin
          $display("%0t saturated: expected %b actual %b", $time, exp_r.sat, res_bus.saturated);
          error_count++;
        end
        if (res_bus.bad_step !== exp_r.bad) begin
          $display("%0t bad_step: expected %b actual %b", $time, exp_r.bad, res_bus.bad_step);
          error_count++;
        end
      end
    end
    res_bus.ready <= !want_idle();
  end

  // Edge cases with the reset limits: extremes, saving the old position, saturation.
  task automatic test_directed_extremes();
    send_fields(ACT_SET_POS, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 16'd0);
    send_fields(ACT_SET_POS, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 16'hFFFF);
    // Both components at the most negative value exceed the largest limit.
    send_fields(ACT_SET_VEL, 32'h8000_0000, 32'h8000_0000, 1'b1, 16'd5);
    send_fields(ACT_SET_ACC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 16'd0);
    send_fields(ACT_VEL_STEP, 32'd0, 32'd0, 1'b1, 16'hFFFF);
    send_fields(ACT_ACC_STEP, 32'hFFFF_FFFF, 32'd1, 1'b0, 16'hFFFF);
    send_fields(ACT_BACKWARD, 32'd0, 32'd0, 1'b0, 16'd1);
    send_fields(ACT_BACKWARD, 32'd0, 32'd0, 1'b1, 16'hFFFF);
    // A zero time step leaves everything as it was.
    send_fields(ACT_VEL_STEP, 32'd7, 32'd7, 1'b0, 16'd0);
    send_fields(ACT_ACC_STEP, 32'd7, 32'd7, 1'b1, 16'd0);
    send_fields(ACT_BACKWARD, 32'd7, 32'd7, 1'b0, 16'd0);
    // Unused action codes.
    send_fields(3'd6, 32'h1234_5678, 32'h8765_4321, 1'b1, 16'd9);
    send_fields(3'd7, 32'hFFFF_FFFF, 32'h0, 1'b0, 16'd0);
    // Small, unclamped motion with a negative velocity, rounding toward minus infinity.
    send_fields(ACT_SET_VEL, 32'hFFFF_FFFF, 32'h0001_8000, 1'b0, 16'd0);
    send_fields(ACT_SET_POS, 32'h0, 32'h0, 1'b1, 16'd0);
    send_fields(ACT_VEL_STEP, 32'd0, 32'd0, 1'b0, 16'd3);
    send_fields(ACT_BACKWARD, 32'd0, 32'd0, 1'b0, 16'd3);
    drain_block();
  endtask

  // A limit of zero turns any nonzero vector into the zero vector.
  task automatic test_zero_limits();
    set_limits(31'd0, 31'd0);
    send_fields(ACT_SET_VEL, 32'd1, 32'd0, 1'b0, 16'd0);
    send_fields(ACT_SET_ACC, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 16'd0);
    send_fields(ACT_SET_VEL, 32'd0, 32'd0, 1'b0, 16'd0);
    send_fields(ACT_ACC_STEP, 32'd0, 32'd0, 1'b0, 16'hFFFF);
    drain_block();
  endtask

  task automatic test_random_phase(logic [30:0] speed, logic [30:0] accel, int unsigned count);
    set_limits(speed, accel);
    for (int unsigned i = 0; i < count; i++) begin
      // Middle part of each phase runs without any idling.
      no_idle = (i >= count / 3) && (i < count / 2);
      send_request(pick_request());
    end
    no_idle = 1'b0;
    drain_block();
  endtask

  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    req_bus.valid = 1'b0;
    req_bus.action        = '0;
    req_bus.vec_x         = '0;
    req_bus.vec_y         = '0;
    req_bus.keep_previous = 1'b0;
    req_bus.time_step     = '0;
    res_bus.ready = 1'b0;
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    no_idle       = 1'b0;
    body_px = 0; body_py = 0; body_qx = 0; body_qy = 0;
    body_vx = 0; body_vy = 0; body_ax = 0; body_ay = 0;
    lim_speed = 64'(LIMIT_RESET);
    lim_accel = 64'(LIMIT_RESET);
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_extremes();
    test_zero_limits();
    test_random_phase(31'h7FFF_FFFF, 31'h7FFF_FFFF, 400);
    test_random_phase(31'h0001_0000, 31'h0000_8000, 400);
    test_random_phase(31'($urandom), 31'($urandom), 400);
    test_random_phase(31'($urandom_range(0, 32'h00FF_FFFF)), 31'h7FFF_FFFF, 400);
    test_random_phase(31'd1, 31'($urandom_range(0, 32'h0010_0000)), 350);

    $display("Sent %0d requests over seven limit settings, %0d results checked, %0d errors.",
             sent_count, checked_count, error_count);
    if (error_count == 0) begin
      $display("body_kinematics_step_test OK");
    end else begin
      $display("body_kinematics_step_test NOT OK");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20ms;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("body_kinematics_step_test NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/bks_pkg.sv
rtl/core/bks_if.sv
rtl/core/bks_ctrl.sv
rtl/core/bks_dp.sv
rtl/core/body_kinematics_step.sv
rtl/core/bks_checker.sv
test/body_kinematics_step_test.sv
